// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the spline evaluator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/crse_pkg.sv
// ----------------------------------------------------------------------------
// crse_pkg
// Widths, constants and types shared by the spline evaluator modules.
// ----------------------------------------------------------------------------
package crse_pkg;

    localparam int KNOT_W = 24;
    localparam int INDEX_W = 5;
    localparam int POS_W = 17;
    localparam int COUNT_W = 6;
    localparam int OUT_W = 26;
    localparam int FRAC_W = 16;
    localparam int F_W = FRAC_W + 1;
    localparam int ACC_W = 32;
    localparam int HI_W = ACC_W + 2;
    localparam int STEP_W = $clog2(F_W);

    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1 << FRAC_W);
    localparam logic signed [ACC_W-1:0] OUT_MAX = (1 <<< (OUT_W - 1)) - 1;
    localparam logic signed [ACC_W-1:0] OUT_MIN = -(1 <<< (OUT_W - 1));

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TMUL,
        S_SPAN,
        S_READ,
        S_COEF,
        S_MSTART,
        S_MWAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

// File: sv/crse_knot_mem.sv
// ----------------------------------------------------------------------------
// crse_knot_mem
// Knot store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module crse_knot_mem #(
    parameter int DEPTH = 32,
    parameter int ADDR_W = 5
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [ADDR_W-1:0]                   i_waddr,
    input  logic signed [crse_pkg::KNOT_W-1:0]  i_wdata,
    input  logic [ADDR_W-1:0]                   i_raddr,
    output logic signed [crse_pkg::KNOT_W-1:0]  o_rdata
);
    import crse_pkg::*;

    logic signed [KNOT_W-1:0] r_mem [DEPTH];
    logic signed [KNOT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/crse_ser_mul.sv
// ----------------------------------------------------------------------------
// crse_ser_mul
// Bit-serial multiplier: one fraction bit per cycle, result is the
// signed product shifted right by the fraction width with floor rounding.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crse_ser_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [crse_pkg::ACC_W-1:0]  i_a,
    input  logic [crse_pkg::F_W-1:0]           i_f,
    output logic signed [crse_pkg::ACC_W-1:0]  o_res,
    output crse_pkg::t_mul_stat                o_stat
);
    import crse_pkg::*;

    logic signed [ACC_W-1:0] r_a;
    logic signed [HI_W-1:0]  r_hi;
    logic [F_W-1:0]          r_f;
    logic                    r_lsb;
    logic [STEP_W-1:0]       r_cnt;
    logic                    r_busy;
    logic                    r_done;
    logic signed [HI_W-1:0]  w_addend;
    logic signed [HI_W-1:0]  w_sum;
    logic [HI_W:0]           w_prod;
    logic                    w_last;

    assign w_addend = r_f[0] ? {{(HI_W - ACC_W){r_a[ACC_W-1]}}, r_a} : '0;
    assign w_sum = r_hi + w_addend;
    assign w_last = (r_cnt == STEP_W'(F_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_f <= i_f;
            r_hi <= '0;
            r_lsb <= 1'b0;
        end else if (r_busy) begin
            r_hi <= w_sum >>> 1;
            r_lsb <= w_sum[0];
            r_f <= r_f >> 1;
        end
    end

    assign w_prod = {r_hi, r_lsb};
    assign o_res = w_prod[ACC_W-1:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    `ASSERT_NEXT(a_done_pulse, r_done, !r_done, "multiplier done lasted more than one cycle")
    `ASSERT_NEXT(a_done_after_last, r_busy && w_last && !i_start, r_done,
        "multiplier did not finish after its last step")
    `ASSERT_NEXT(a_start_busy, i_start, r_busy, "multiplier did not start after a start pulse")

endmodule

// File: sv/catmull_rom_spline_eval_core.sv
// ----------------------------------------------------------------------------
// catmull_rom_spline_eval_core
// Uniform Catmull-Rom spline evaluator with a 1.16 fixed-point position over a knot store.
// ----------------------------------------------------------------------------
//  channel | signals                                        | direction
//  request | i_valid, o_ready, i_cmd, i_knot_index,          | in
//          | i_knot_value, i_position, i_knot_count          |
//  result  | o_valid, i_ready, o_curve_value                 | out
//
// A load request writes the knot store and gives no result.
// An evaluate request forms the position product, picks the span, reads four
// knots, builds the coefficients and then makes three passes of the bit-serial
// multiplier.
// Reset is synchronous and active low; the knot store is not cleared.
// A finished result waits in the output register while the next request is
// taken; evaluation holds in its last state until that register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module catmull_rom_spline_eval_core #(
    parameter int MAX_KNOTS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_cmd,
    input  logic [crse_pkg::INDEX_W-1:0]         i_knot_index,
    input  logic signed [crse_pkg::KNOT_W-1:0]   i_knot_value,
    input  logic [crse_pkg::POS_W-1:0]           i_position,
    input  logic [crse_pkg::COUNT_W-1:0]         i_knot_count,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [crse_pkg::OUT_W-1:0]    o_curve_value
);
    import crse_pkg::*;

    localparam int IDX_W = $clog2(MAX_KNOTS);
    localparam int N_W = $clog2(MAX_KNOTS + 1);
    localparam int T_W = POS_W + N_W;
    localparam int CNT_W = $clog2(N_W + 5);

    t_state                  r_state;
    t_state                  n_state;
    logic [POS_W-1:0]        r_pos;
    logic [N_W-1:0]          r_n;
    logic [N_W-1:0]          r_m;
    logic [T_W-1:0]          r_t;
    logic [CNT_W-1:0]        r_cnt;
    logic [IDX_W-1:0]        r_span;
    logic [F_W-1:0]          r_f;
    logic signed [KNOT_W-1:0] r_k0;
    logic signed [KNOT_W-1:0] r_k1;
    logic signed [KNOT_W-1:0] r_k2;
    logic signed [KNOT_W-1:0] r_k3;
    logic signed [ACC_W-1:0] r_c1;
    logic signed [ACC_W-1:0] r_c2;
    logic signed [ACC_W-1:0] r_c3;
    logic signed [ACC_W-1:0] r_acc;
    logic [1:0]              r_pass;
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out;

    logic                    w_accept;
    logic                    w_mem_we;
    logic                    w_mul_start;
    logic                    w_out_load;
    logic [N_W-1:0]          w_n_clamp;
    logic [POS_W-1:0]        w_pos_sat;
    logic [T_W-FRAC_W-1:0]   w_span_raw;
    logic [N_W-1:0]          w_span_lim;
    logic [IDX_W-1:0]        w_raddr;
    logic signed [KNOT_W-1:0] w_rdata;
    logic signed [ACC_W-1:0] w_k0;
    logic signed [ACC_W-1:0] w_k1;
    logic signed [ACC_W-1:0] w_k2;
    logic signed [ACC_W-1:0] w_k3;
    logic signed [ACC_W-1:0] w_nk0;
    logic signed [ACC_W-1:0] w_mul_a;
    logic signed [ACC_W-1:0] w_mul_res;
    logic signed [ACC_W-1:0] w_addend;
    logic signed [ACC_W-1:0] w_acc_next;
    logic signed [ACC_W-1:0] w_sat;
    t_mul_stat               w_mul_stat;

    assign w_accept = i_valid && o_ready;

    always_comb begin
        if (i_knot_count < COUNT_W'(4)) begin
            w_n_clamp = N_W'(4);
        end else if (32'(i_knot_count) > MAX_KNOTS) begin
            w_n_clamp = N_W'(MAX_KNOTS);
        end else begin
            w_n_clamp = N_W'(i_knot_count);
        end
        w_pos_sat = (i_position > POS_ONE) ? POS_ONE : i_position;
    end

    assign w_span_raw = r_t[T_W-1:FRAC_W];
    assign w_span_lim = r_n - N_W'(4);
    assign w_raddr = r_span + IDX_W'(r_cnt[1:0]);

    crse_knot_mem #(
        .DEPTH (MAX_KNOTS),
        .ADDR_W(IDX_W)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_mem_we),
        .i_waddr(IDX_W'(i_knot_index)),
        .i_wdata(i_knot_value),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_k0 = {{(ACC_W - KNOT_W){r_k0[KNOT_W-1]}}, r_k0};
    assign w_k1 = {{(ACC_W - KNOT_W){r_k1[KNOT_W-1]}}, r_k1};
    assign w_k2 = {{(ACC_W - KNOT_W){r_k2[KNOT_W-1]}}, r_k2};
    assign w_k3 = {{(ACC_W - KNOT_W){r_k3[KNOT_W-1]}}, r_k3};
    assign w_nk0 = ~w_k0;

    assign w_mul_a = (r_pass == 2'd0) ? r_c1 : r_acc;

    crse_ser_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_mul_start),
        .i_a    (w_mul_a),
        .i_f    (r_f),
        .o_res  (w_mul_res),
        .o_stat (w_mul_stat)
    );

    always_comb begin
        case (r_pass)
            2'd0:    w_addend = r_c2;
            2'd1:    w_addend = r_c3;
            default: w_addend = w_k1;
        endcase
    end

    assign w_acc_next = w_mul_res + w_addend;

    always_comb begin
        if (r_acc > OUT_MAX) begin
            w_sat = OUT_MAX;
        end else if (r_acc < OUT_MIN) begin
            w_sat = OUT_MIN;
        end else begin
            w_sat = r_acc;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_cmd == CMD_EVAL) begin
                    n_state = S_TMUL;
                end
            end
            S_TMUL: begin
                if (r_cnt == CNT_W'(N_W - 1)) begin
                    n_state = S_SPAN;
                end
            end
            S_SPAN: n_state = S_READ;
            S_READ: begin
                if (r_cnt == CNT_W'(4)) begin
                    n_state = S_COEF;
                end
            end
            S_COEF:   n_state = S_MSTART;
            S_MSTART: n_state = S_MWAIT;
            S_MWAIT: begin
                if (w_mul_stat.done) begin
                    n_state = (r_pass == 2'd2) ? S_DONE : S_MSTART;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        w_mem_we = 1'b0;
        w_mul_start = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                w_mem_we = w_accept && (i_cmd == CMD_LOAD)
                    && (32'(i_knot_index) < MAX_KNOTS);
            end
            S_MSTART: w_mul_start = 1'b1;
            S_DONE:   w_out_load = !r_out_valid || i_ready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt <= '0;
            r_pass <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    r_pass <= '0;
                end
                S_TMUL:  r_cnt <= (r_cnt == CNT_W'(N_W - 1)) ? '0 : r_cnt + 1'b1;
                S_READ:  r_cnt <= r_cnt + 1'b1;
                S_MWAIT: begin
                    if (w_mul_stat.done) begin
                        r_pass <= r_pass + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_pos <= w_pos_sat;
                r_n <= w_n_clamp;
                r_m <= w_n_clamp - N_W'(3);
                r_t <= '0;
            end
            S_TMUL: begin
                r_t <= (r_t << 1) + (r_m[N_W-1] ? T_W'(r_pos) : '0);
                r_m <= r_m << 1;
            end
            S_SPAN: begin
                if (w_span_raw > (T_W - FRAC_W)'(w_span_lim)) begin
                    r_span <= IDX_W'(w_span_lim);
                    r_f <= F_W'(POS_ONE);
                end else begin
                    r_span <= IDX_W'(w_span_raw);
                    r_f <= {1'b0, r_t[FRAC_W-1:0]};
                end
            end
            S_READ: begin
                if (r_cnt != '0) begin
                    r_k0 <= r_k1;
                    r_k1 <= r_k2;
                    r_k2 <= r_k3;
                    r_k3 <= w_rdata;
                end
            end
            S_COEF: begin
                r_c1 <= w_k1 + (w_k1 >>> 1) - w_k2 - (w_k2 >>> 1) + (w_k3 >>> 1)
                    + (w_nk0 >>> 1);
                r_c2 <= w_k0 - (w_k1 <<< 1) - (w_k1 >>> 1) + (w_k2 <<< 1)
                    - (w_k3 >>> 1);
                r_c3 <= (w_k2 >>> 1) + (w_nk0 >>> 1);
            end
            S_MWAIT: begin
                if (w_mul_stat.done) begin
                    r_acc <= w_acc_next;
                end
            end
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_out <= w_sat[OUT_W-1:0];
        end
    end

    assign o_valid = r_out_valid;
    assign o_curve_value = r_out;

    `ASSERT_SAME(a_mul_active, r_state == S_MWAIT, w_mul_stat.busy || w_mul_stat.done,
        "waiting on a multiplier that is neither busy nor done")
    `ASSERT_NEXT(a_eval_starts, w_accept && i_cmd == CMD_EVAL, r_state == S_TMUL,
        "evaluate request did not start the position product")
    `ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_curve_value),
        "waiting result changed or dropped before it was taken")

endmodule

// File: sim/tb_catmull_rom_spline_eval_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_catmull_rom_spline_eval_core
// Self-checking bench for the Catmull-Rom spline evaluator. Knots are loaded
// and curve positions evaluated through the request channel. A predictor keeps
// its own copy of the knot store and works out each curve value in 64-bit
// fixed point. Results are checked in order against those expectations while
// both channels idle and stall at random outside the gap-free phases.
// ----------------------------------------------------------------------------
module tb_catmull_rom_spline_eval_core;

    import crse_pkg::*;

    localparam int KNOT_SLOTS = 32;
    localparam int MIN_KNOTS = 4;
    localparam longint UNIT = longint'(1) << FRAC_W;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES = 100;
    localparam int REPORT_LIMIT = 10;
    localparam logic signed [KNOT_W-1:0] KNOT_MAX = {1'b0, {(KNOT_W-1){1'b1}}};
    localparam logic signed [KNOT_W-1:0] KNOT_MIN = {1'b1, {(KNOT_W-1){1'b0}}};
    localparam logic [POS_W-1:0] POS_FULL = {POS_W{1'b1}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_cmd = CMD_LOAD;
    logic [INDEX_W-1:0] i_knot_index = '0;
    logic signed [KNOT_W-1:0] i_knot_value = '0;
    logic [POS_W-1:0] i_position = '0;
    logic [COUNT_W-1:0] i_knot_count = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [OUT_W-1:0] o_curve_value;

    logic signed [KNOT_W-1:0] knot_mirror [KNOT_SLOTS];
    logic signed [OUT_W-1:0] curve_expect_q [$];
    int mismatch_count = 0;
    int ready_hold = 0;
    int quiet_cycles = 0;
    bit no_gaps = 1'b0;

    catmull_rom_spline_eval_core #(
        .MAX_KNOTS(KNOT_SLOTS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_cmd(i_cmd),
        .i_knot_index(i_knot_index),
        .i_knot_value(i_knot_value),
        .i_position(i_position),
        .i_knot_count(i_knot_count),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_curve_value(o_curve_value)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic logic signed [OUT_W-1:0] spline_value(logic [POS_W-1:0] position,
                                                            logic [COUNT_W-1:0] count);
        longint pos, n, t, span, f, k0, k1, k2, k3, c1, c2, c3, acc;
        pos = position;
        n = count;
        if (pos > UNIT) pos = UNIT;
        if (n < MIN_KNOTS) n = MIN_KNOTS;
        if (n > KNOT_SLOTS) n = KNOT_SLOTS;
        t = pos * (n - 3);
        span = t >>> FRAC_W;
        if (span > n - MIN_KNOTS) span = n - MIN_KNOTS;
        f = t - span * UNIT;
        k0 = knot_mirror[span];
        k1 = knot_mirror[span + 1];
        k2 = knot_mirror[span + 2];
        k3 = knot_mirror[span + 3];
        c1 = k1 + (k1 >>> 1) - k2 - (k2 >>> 1) + (k3 >>> 1) + ((~k0) >>> 1);
        c2 = k0 - 2 * k1 - (k1 >>> 1) + 2 * k2 - (k3 >>> 1);
        c3 = (k2 >>> 1) + ((~k0) >>> 1);
        acc = ((f * c1) >>> FRAC_W) + c2;
        acc = ((f * acc) >>> FRAC_W) + c3;
        acc = ((f * acc) >>> FRAC_W) + k1;
        if (acc > longint'(OUT_MAX)) acc = OUT_MAX;
        if (acc < longint'(OUT_MIN)) acc = OUT_MIN;
        return OUT_W'(acc);
    endfunction

    function automatic void note_mismatch(string what, logic signed [OUT_W-1:0] want,
                                          logic signed [OUT_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("Mismatch at %0t: %s, curve_value expected %0d (0x%h), got %0d (0x%h)",
                     $realtime, what, want, want, got, got);
        end
    endfunction

    task automatic send_request(logic cmd, logic [INDEX_W-1:0] idx,
                                logic signed [KNOT_W-1:0] value,
                                logic [POS_W-1:0] pos, logic [COUNT_W-1:0] count);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_knot_index <= idx;
        i_knot_value <= value;
        i_position <= pos;
        i_knot_count <= count;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (cmd == CMD_LOAD) begin
            knot_mirror[idx] = value;
        end else begin
            curve_expect_q.push_back(spline_value(pos, count));
        end
    endtask

    task automatic load_knot(logic [INDEX_W-1:0] idx, logic signed [KNOT_W-1:0] value);
        send_request(CMD_LOAD, idx, value, POS_W'($urandom), COUNT_W'($urandom));
    endtask

    task automatic evaluate(logic [POS_W-1:0] pos, logic [COUNT_W-1:0] count);
        send_request(CMD_EVAL, INDEX_W'($urandom), KNOT_W'($urandom), pos, count);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (curve_expect_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_item();
        int roll;
        logic signed [KNOT_W-1:0] value;
        logic [POS_W-1:0] pos;
        logic [COUNT_W-1:0] count;
        roll = $urandom_range(0, 15);
        value = KNOT_W'($urandom);
        if (roll == 0) value = KNOT_MAX;
        if (roll == 1) value = KNOT_MIN;
        if ($urandom_range(0, 9) < 3) begin
            load_knot(INDEX_W'($urandom), value);
        end else begin
            pos = POS_W'($urandom_range(0, 32'(UNIT)));
            if (roll == 2) pos = POS_W'(UNIT);
            if (roll == 3) pos = '0;
            if (roll == 4 || roll == 5) pos = POS_W'($urandom);
            count = COUNT_W'($urandom_range(MIN_KNOTS, KNOT_SLOTS));
            if (roll >= 12) count = COUNT_W'($urandom);
            evaluate(pos, count);
        end
    endtask

    task automatic test_extreme_knots();
        load_knot(INDEX_W'(0), KNOT_MAX);
        load_knot(INDEX_W'(1), KNOT_MIN);
        load_knot(INDEX_W'(2), KNOT_MAX);
        load_knot(INDEX_W'(3), KNOT_MIN);
        evaluate(POS_W'(0), COUNT_W'(MIN_KNOTS));
        evaluate(POS_W'(UNIT / 2), COUNT_W'(MIN_KNOTS));
        evaluate(POS_W'(UNIT), COUNT_W'(MIN_KNOTS));
        evaluate(POS_W'(UNIT / 4), COUNT_W'(0));
        load_knot(INDEX_W'(0), KNOT_MIN);
        load_knot(INDEX_W'(1), KNOT_MAX);
        load_knot(INDEX_W'(2), KNOT_MIN);
        load_knot(INDEX_W'(3), KNOT_MAX);
        evaluate(POS_W'(UNIT / 2), COUNT_W'(MIN_KNOTS));
        evaluate(POS_W'(UNIT * 3 / 4), COUNT_W'(1));
        evaluate(POS_W'(UNIT - 1), COUNT_W'(3));
    endtask

    task automatic test_store_fill();
        for (int i = 0; i < KNOT_SLOTS; i++) begin
            load_knot(INDEX_W'(i), KNOT_W'($urandom));
        end
    endtask

    task automatic test_clamped_inputs();
        evaluate(POS_W'(0), COUNT_W'(KNOT_SLOTS));
        evaluate(POS_W'(UNIT - 1), COUNT_W'(KNOT_SLOTS));
        evaluate(POS_W'(UNIT), COUNT_W'(KNOT_SLOTS));
        evaluate(POS_W'(UNIT + 1), COUNT_W'(KNOT_SLOTS));
        evaluate(POS_FULL, COUNT_W'(17));
        evaluate(POS_W'(UNIT / 3), COUNT_W'(KNOT_SLOTS + 1));
        evaluate(POS_W'(UNIT / 2), {COUNT_W{1'b1}});
        evaluate(POS_FULL, {COUNT_W{1'b1}});
    endtask

    task automatic test_drain_pause();
        repeat (12) random_item();
        wait_drained();
        repeat (12) random_item();
    endtask

    task automatic test_random(int items);
        for (int i = 0; i < items; i++) begin
            no_gaps = ((i / 150) % 3 == 1);
            random_item();
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            i_ready <= 1'b0;
        end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
            ready_hold = pick_gap();
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : curve_check
        logic signed [OUT_W-1:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (curve_expect_q.size() == 0) begin
                note_mismatch("result with no request outstanding", 'x, o_curve_value);
            end else begin
                want = curve_expect_q.pop_front();
                if (o_curve_value !== want) begin
                    note_mismatch("wrong curve value", want, o_curve_value);
                end
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Watchdog expired after %0d cycles without a handshake", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extreme_knots();
        test_store_fill();
        test_clamped_inputs();
        test_drain_pause();
        test_random(1000);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && curve_expect_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
